// ----- src/cpp_pkg.sv -----
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared constants and the sequencer state type for the polyline
// closest-point search.
// ----------------------------------------------------------------------------
`default_nettype none

package cpp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int PARAM_WIDTH_DEF = 16;
  // Projection fraction is always unsigned Q0.16
  localparam int FRAC_BITS = 16;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_T0,
    ST_T1,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_CMP,
    ST_DIV,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_DX,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_UPD,
    ST_OUT
  } cpp_state_t;

endpackage

`default_nettype wire

// ----- src/cpp_in_if.sv -----
// ----------------------------------------------------------------------------
// cpp_in_if
// Vertex request channel: valid/ready with one polyline sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpp_in_if #(
  parameter int COORD_WIDTH = 16,
  parameter int PARAM_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          first_item;
  logic                          last_item;
  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic        [PARAM_WIDTH-1:0] vertex_param;

  modport source (
    output valid, first_item, last_item, query_x, query_y,
           vertex_x, vertex_y, vertex_param,
    input  ready
  );
  modport sink (
    input  valid, first_item, last_item, query_x, query_y,
           vertex_x, vertex_y, vertex_param,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/cpp_out_if.sv -----
// ----------------------------------------------------------------------------
// cpp_out_if
// Result request channel: valid/ready with the closest point found.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpp_out_if #(
  parameter int COORD_WIDTH = 16,
  parameter int PARAM_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] closest_x;
  logic signed [COORD_WIDTH-1:0] closest_y;
  logic        [2*COORD_WIDTH:0] distance_sq;
  logic        [PARAM_WIDTH-1:0] closest_param;

  modport source (
    output valid, closest_x, closest_y, distance_sq, closest_param,
    input  ready
  );
  modport sink (
    input  valid, closest_x, closest_y, distance_sq, closest_param,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/closest_point_on_polyline.sv -----
// ----------------------------------------------------------------------------
// closest_point_on_polyline
// Streaming search for the polyline point closest to a query point.
// ----------------------------------------------------------------------------
// Each vertex request after the first closes one segment from the previous
// vertex. A small sequencer drives one shared multiplier and a divider
// that makes one quotient bit per cycle. An interior projection takes the
// 16-step fraction divide plus nine passes through the multiplier; a first
// item and a segment whose projection clamps to an end skip the divide. A
// last item also loads the result register; the block is not ready while an
// item is in work or while a result waits for the previous one to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_polyline
  import cpp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cpp_in_if.sink     vertex,
  cpp_out_if.source  result
);

  localparam int CW  = COORD_WIDTH;
  localparam int PW  = PARAM_WIDTH;
  localparam int MW0 = (CW > PW) ? CW : PW;
  localparam int MW  = ((MW0 > FRAC_BITS) ? MW0 : FRAC_BITS) + 1;
  localparam int AW  = 2 * MW + 1;
  localparam int DW  = 2 * CW + 2;
  localparam logic signed [2*MW-1:0] HALF = (2*MW)'(1) << (FRAC_BITS - 1);

  cpp_state_t state, state_next;

  logic                 first_r, last_r;
  logic signed [CW-1:0] vx, vy, qx, qy, prev_vx, prev_vy;
  logic        [PW-1:0] vp, prev_vp;
  logic signed [CW:0]   mx, my, ax, ay, dx, dy;
  logic signed [PW:0]   dp;
  logic signed [AW-1:0] t_acc, mm_acc;
  logic [FRAC_BITS-1:0] frac;
  logic signed [CW-1:0] px, py, best_px, best_py;
  logic        [PW-1:0] pp, best_pp;
  logic        [DW-1:0] d, best_d;
  logic                 out_valid;
  logic signed [CW-1:0] res_x, res_y;
  logic        [2*CW:0] res_d;
  logic        [PW-1:0] res_p;

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] prod;
  logic signed [2*MW-1:0] rnd;
  logic                   div_start, div_done;
  logic [FRAC_BITS-1:0]   div_quo;
  logic                   out_free;

  assign vertex.ready         = (state == ST_IDLE);
  assign result.valid         = out_valid;
  assign result.closest_x     = res_x;
  assign result.closest_y     = res_y;
  assign result.distance_sq   = res_d;
  assign result.closest_param = res_p;
  assign out_free             = !out_valid || result.ready;
  assign div_start            = (state == ST_CMP) && (t_acc > 0) && (t_acc < mm_acc);
  // Round to nearest, ties toward plus infinity
  assign rnd                  = (prod + HALF) >>> FRAC_BITS;

  cpp_mul #(.MW(MW)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  cpp_div #(.AW(AW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (t_acc),
    .den   (mm_acc),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = MW'(mx);
    mul_b = MW'(ax);
    case (state)
      ST_T1: begin
        mul_a = MW'(my);
        mul_b = MW'(ay);
      end
      ST_M0: begin
        mul_a = MW'(mx);
        mul_b = MW'(mx);
      end
      ST_M1: begin
        mul_a = MW'(my);
        mul_b = MW'(my);
      end
      ST_P0: begin
        mul_a = MW'(mx);
        mul_b = MW'({1'b0, frac});
      end
      ST_P1: begin
        mul_a = MW'(my);
        mul_b = MW'({1'b0, frac});
      end
      ST_P2: begin
        mul_a = MW'(dp);
        mul_b = MW'({1'b0, frac});
      end
      ST_D0: begin
        mul_a = MW'(dx);
        mul_b = MW'(dx);
      end
      ST_D1: begin
        mul_a = MW'(dy);
        mul_b = MW'(dy);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (vertex.valid) state_next = ST_PREP;
      ST_PREP: state_next = first_r ? ST_DX : ST_T0;
      ST_T0:   state_next = ST_T1;
      ST_T1:   state_next = ST_M0;
      ST_M0:   state_next = ST_M1;
      ST_M1:   state_next = ST_M2;
      ST_M2:   state_next = ST_CMP;
      ST_CMP:  state_next = div_start ? ST_DIV : ST_DX;
      ST_DIV:  if (div_done) state_next = ST_P0;
      ST_P0:   state_next = ST_P1;
      ST_P1:   state_next = ST_P2;
      ST_P2:   state_next = ST_P3;
      ST_P3:   state_next = ST_DX;
      ST_DX:   state_next = ST_D0;
      ST_D0:   state_next = ST_D1;
      ST_D1:   state_next = ST_D2;
      ST_D2:   state_next = ST_UPD;
      ST_UPD:  state_next = last_r ? ST_OUT : ST_IDLE;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Search state that reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      qx      <= '0;
      qy      <= '0;
      prev_vx <= '0;
      prev_vy <= '0;
      prev_vp <= '0;
      best_px <= '0;
      best_py <= '0;
      best_pp <= '0;
      best_d  <= '0;
    end else begin
      if (state == ST_IDLE && vertex.valid && vertex.first_item) begin
        qx <= vertex.query_x;
        qy <= vertex.query_y;
      end
      if (state == ST_UPD) begin
        if (first_r || d < best_d) begin
          best_px <= px;
          best_py <= py;
          best_pp <= pp;
          best_d  <= d;
        end
        prev_vx <= vx;
        prev_vy <= vy;
        prev_vp <= vp;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        first_r <= vertex.first_item;
        last_r  <= vertex.last_item;
        vx      <= vertex.vertex_x;
        vy      <= vertex.vertex_y;
        vp      <= vertex.vertex_param;
      end
      ST_PREP: begin
        mx <= (CW+1)'(vx) - (CW+1)'(prev_vx);
        my <= (CW+1)'(vy) - (CW+1)'(prev_vy);
        ax <= (CW+1)'(qx) - (CW+1)'(prev_vx);
        ay <= (CW+1)'(qy) - (CW+1)'(prev_vy);
        dp <= $signed({1'b0, vp}) - $signed({1'b0, prev_vp});
        px <= vx;
        py <= vy;
        pp <= vp;
      end
      ST_T1: t_acc  <= AW'(prod);
      ST_M0: t_acc  <= t_acc + AW'(prod);
      ST_M1: mm_acc <= AW'(prod);
      ST_M2: mm_acc <= mm_acc + AW'(prod);
      ST_CMP: begin
        // Projection at or before the start clamps to the start vertex
        if (t_acc <= 0) begin
          px <= prev_vx;
          py <= prev_vy;
          pp <= prev_vp;
        end
      end
      ST_DIV: frac <= div_quo;
      ST_P1:  px <= prev_vx + CW'(rnd);
      ST_P2:  py <= prev_vy + CW'(rnd);
      ST_P3:  pp <= prev_vp + PW'(rnd);
      ST_DX: begin
        dx <= (CW+1)'(qx) - (CW+1)'(px);
        dy <= (CW+1)'(qy) - (CW+1)'(py);
      end
      ST_D1: d <= DW'(prod);
      ST_D2: d <= d + DW'(prod);
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      res_x <= best_px;
      res_y <= best_py;
      res_d <= best_d[2*CW:0];
      res_p <= best_pp;
    end
  end

endmodule

`default_nettype wire

// ----- src/cpp_mul.sv -----
// ----------------------------------------------------------------------------
// cpp_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_mul #(
  parameter int MW = 17
) (
  input  wire logic                   clk,
  input  wire logic signed [MW-1:0]   a,
  input  wire logic signed [MW-1:0]   b,
  output logic signed [2*MW-1:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

// ----- src/cpp_div.sv -----
// ----------------------------------------------------------------------------
// cpp_div
// Restoring divider for the projection fraction: num * 2^FRAC_BITS / den,
// one quotient bit per cycle. Requires num < den.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_div
  import cpp_pkg::*;
#(
  parameter int AW = 35
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [AW-1:0]        num,
  input  wire logic [AW-1:0]        den,
  output logic                      done,
  output logic [FRAC_BITS-1:0]      quo
);

  localparam int CNTW = $clog2(FRAC_BITS + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [AW:0]     rem;
  logic [AW:0]     shifted;

  assign shifted = {rem[AW-1:0], 1'b0};
  assign done    = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNTW'(FRAC_BITS);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      quo <= '0;
    end else if (busy && cnt != '0) begin
      if (shifted >= {1'b0, den}) begin
        rem <= shifted - {1'b0, den};
        quo <= {quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire
